// File: design/sple_pkg.sv
package sple_pkg;

   localparam int Capacity = 128;
   localparam int SlotW    = $clog2(Capacity);
   localparam int LinkW    = $clog2(Capacity + 1);
   localparam logic [LinkW-1:0] Null = LinkW'(Capacity);

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_DELETE = 2'd1,
      REQ_CHANGE = 2'd2,
      REQ_SEARCH = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_DUP     = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_START,
      DP_STEP,
      DP_RESTART,
      DP_INS_RD,
      DP_INS_WR,
      DP_INS_LINK,
      DP_DEL_UNLINK,
      DP_DEL_FREE,
      DP_CHG_UNLINK,
      DP_CHG_MOVE,
      DP_CHG_LINK,
      DP_LOAD_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic       save;
      logic       res_en;
      status_type res_status;
   } cmd_type;

   typedef struct packed {
      req_kind_type kind;
      logic         done;
      logic         hit;
      logic         full;
      logic         same_key;
      logic         rsp_free;
   } sts_type;

endpackage

// File: design/sple_datapath.sv
module sple_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  sple_pkg::cmd_type             cmd,
   output sple_pkg::sts_type             sts,
   input  logic [1:0]                    req_type,
   input  logic signed [31:0]            req_key,
   input  logic signed [31:0]            req_new_key,
   input  logic [7:0]                    req_age,
   input  logic [31:0]                   req_name_ref,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [sple_pkg::SlotW-1:0]    rsp_slot,
   output logic [sple_pkg::LinkW-1:0]    rsp_count
);

   localparam int SW = sple_pkg::SlotW;
   localparam int LW = sple_pkg::LinkW;

   logic signed [31:0] key_mem  [sple_pkg::Capacity];
   logic [7:0]         age_mem  [sple_pkg::Capacity];
   logic [31:0]        name_mem [sple_pkg::Capacity];
   logic [LW-1:0]      link_mem [sple_pkg::Capacity];
   logic [sple_pkg::Capacity-1:0] link_vld_ff;

   sple_pkg::req_kind_type kind_ff;
   logic signed [31:0] key_ff, new_key_ff;
   logic [7:0]         age_ff;
   logic [31:0]        name_ff;
   logic               tgt_nk_ff;
   logic [LW-1:0]      cur_ff, prev_ff, head_ff, free_ff, count_ff, sprev_ff, snext_ff;
   logic [SW-1:0]      slot_ff;
   logic signed [31:0] key_q_ff;
   logic [LW-1:0]      link_q_ff;
   sple_pkg::status_type res_status_ff;
   logic [SW-1:0]      res_slot_ff;
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [SW-1:0]      rsp_slot_ff;
   logic [LW-1:0]      rsp_count_ff;

   logic signed [31:0] target;
   logic               rd_en;
   logic [LW-1:0]      rd_addr;
   logic               lw_en;
   logic [SW-1:0]      lw_addr;
   logic [LW-1:0]      lw_data;
   logic [LW-1:0]      place, nxt;
   logic [SW-1:0]      res_slot_in;
   logic [LW-1:0]      slot_ext;

   assign target   = tgt_nk_ff ? new_key_ff : key_ff;
   assign slot_ext = LW'(slot_ff);
   assign place    = (prev_ff == slot_ext) ? sprev_ff : prev_ff;
   assign nxt      = (cur_ff == slot_ext) ? snext_ff : cur_ff;

   assign sts.kind     = kind_ff;
   assign sts.done     = (cur_ff == sple_pkg::Null) || (key_q_ff >= target);
   assign sts.hit      = (cur_ff != sple_pkg::Null) && (key_q_ff == target);
   assign sts.full     = (free_ff == sple_pkg::Null);
   assign sts.same_key = (key_ff == new_key_ff);
   assign sts.rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = head_ff;
      lw_en   = 1'b0;
      lw_addr = slot_ff;
      lw_data = cur_ff;
      case (cmd.op)
         sple_pkg::DP_START, sple_pkg::DP_RESTART: begin
            rd_en = 1'b1;
         end
         sple_pkg::DP_STEP: begin
            rd_en   = 1'b1;
            rd_addr = link_q_ff;
         end
         sple_pkg::DP_INS_RD: begin
            rd_en   = 1'b1;
            rd_addr = free_ff;
         end
         sple_pkg::DP_INS_WR: begin
            lw_en = 1'b1;
         end
         sple_pkg::DP_INS_LINK: begin
            lw_en   = (prev_ff != sple_pkg::Null);
            lw_addr = prev_ff[SW-1:0];
            lw_data = slot_ext;
         end
         sple_pkg::DP_DEL_UNLINK: begin
            lw_en   = (prev_ff != sple_pkg::Null);
            lw_addr = prev_ff[SW-1:0];
            lw_data = link_q_ff;
         end
         sple_pkg::DP_DEL_FREE: begin
            lw_en   = 1'b1;
            lw_data = free_ff;
         end
         sple_pkg::DP_CHG_UNLINK: begin
            lw_en   = (sprev_ff != sple_pkg::Null);
            lw_addr = sprev_ff[SW-1:0];
            lw_data = snext_ff;
         end
         sple_pkg::DP_CHG_MOVE: begin
            lw_en   = 1'b1;
            lw_data = nxt;
         end
         sple_pkg::DP_CHG_LINK: begin
            lw_en   = (place != sple_pkg::Null);
            lw_addr = place[SW-1:0];
            lw_data = slot_ext;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (lw_en) begin
         link_mem[lw_addr] <= lw_data;
      end
      if (cmd.op == sple_pkg::DP_INS_WR) begin
         key_mem[slot_ff]  <= key_ff;
         age_mem[slot_ff]  <= age_ff;
         name_mem[slot_ff] <= name_ff;
      end
      if (cmd.op == sple_pkg::DP_CHG_MOVE) begin
         key_mem[slot_ff] <= new_key_ff;
      end
      if (rd_en) begin
         key_q_ff  <= key_mem[rd_addr[SW-1:0]];
         link_q_ff <= link_vld_ff[rd_addr[SW-1:0]] ? link_mem[rd_addr[SW-1:0]]
                                                   : LW'(rd_addr[SW-1:0]) + LW'(1);
      end
   end

   assign res_slot_in = (cmd.res_status != sple_pkg::ST_OK) ? '0
                      : (cmd.save ? cur_ff[SW-1:0] : slot_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= sple_pkg::Null;
         free_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         link_vld_ff  <= '0;
      end else begin
         if (cmd.op == sple_pkg::DP_LOAD_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (lw_en) begin
            link_vld_ff[lw_addr] <= 1'b1;
         end
         case (cmd.op)
            sple_pkg::DP_INS_WR:  free_ff <= link_q_ff;
            sple_pkg::DP_INS_LINK: begin
               if (prev_ff == sple_pkg::Null) begin
                  head_ff <= slot_ext;
               end
               count_ff <= count_ff + LW'(1);
            end
            sple_pkg::DP_DEL_UNLINK: begin
               if (prev_ff == sple_pkg::Null) begin
                  head_ff <= link_q_ff;
               end
            end
            sple_pkg::DP_DEL_FREE: begin
               free_ff <= slot_ext;
               if (count_ff != '0) begin
                  count_ff <= count_ff - LW'(1);
               end
            end
            sple_pkg::DP_CHG_UNLINK: begin
               if (sprev_ff == sple_pkg::Null) begin
                  head_ff <= snext_ff;
               end
            end
            sple_pkg::DP_CHG_LINK: begin
               if (place == sple_pkg::Null) begin
                  head_ff <= slot_ext;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         sple_pkg::DP_START: begin
            kind_ff    <= sple_pkg::req_kind_type'(req_type);
            key_ff     <= req_key;
            new_key_ff <= req_new_key;
            age_ff     <= req_age;
            name_ff    <= req_name_ref;
            cur_ff     <= head_ff;
            prev_ff    <= sple_pkg::Null;
            tgt_nk_ff  <= 1'b0;
         end
         sple_pkg::DP_RESTART: begin
            cur_ff    <= head_ff;
            prev_ff   <= sple_pkg::Null;
            tgt_nk_ff <= 1'b1;
         end
         sple_pkg::DP_STEP: begin
            prev_ff <= cur_ff;
            cur_ff  <= link_q_ff;
         end
         sple_pkg::DP_INS_RD:  slot_ff <= free_ff[SW-1:0];
         sple_pkg::DP_LOAD_OUT: begin
            rsp_status_ff <= res_status_ff;
            rsp_slot_ff   <= res_slot_ff;
            rsp_count_ff  <= count_ff;
         end
         default: begin
         end
      endcase
      if (cmd.save) begin
         slot_ff  <= cur_ff[SW-1:0];
         sprev_ff <= prev_ff;
         snext_ff <= link_q_ff;
      end
      if (cmd.res_en) begin
         res_status_ff <= cmd.res_status;
         res_slot_ff   <= res_slot_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

// File: design/sple_controller.sv
module sple_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sple_pkg::sts_type    sts,
   output sple_pkg::cmd_type    cmd
);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_WALK  = 9'b000000010,
      S_WALK2 = 9'b000000100,
      S_INS_A = 9'b000001000,
      S_INS_B = 9'b000010000,
      S_DEL_A = 9'b000100000,
      S_CHG_A = 9'b001000000,
      S_CHG_B = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in       = state_ff;
      cmd.op         = sple_pkg::DP_NONE;
      cmd.save       = 1'b0;
      cmd.res_en     = 1'b0;
      cmd.res_status = sple_pkg::ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = sple_pkg::DP_START;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (!sts.done) begin
               cmd.op = sple_pkg::DP_STEP;
            end else begin
               unique case (sts.kind)
                  sple_pkg::REQ_INSERT: begin
                     if (sts.full || sts.hit) begin
                        cmd.res_en     = 1'b1;
                        cmd.res_status = sts.full ? sple_pkg::ST_FULL : sple_pkg::ST_DUP;
                        state_in       = S_DONE;
                     end else begin
                        cmd.op   = sple_pkg::DP_INS_RD;
                        state_in = S_INS_A;
                     end
                  end
                  sple_pkg::REQ_DELETE: begin
                     if (!sts.hit) begin
                        cmd.res_en     = 1'b1;
                        cmd.res_status = sple_pkg::ST_MISSING;
                        state_in       = S_DONE;
                     end else begin
                        cmd.save = 1'b1;
                        cmd.op   = sple_pkg::DP_DEL_UNLINK;
                        state_in = S_DEL_A;
                     end
                  end
                  sple_pkg::REQ_CHANGE: begin
                     cmd.save = 1'b1;
                     if (!sts.hit) begin
                        cmd.res_en     = 1'b1;
                        cmd.res_status = sple_pkg::ST_MISSING;
                        state_in       = S_DONE;
                     end else if (sts.same_key) begin
                        cmd.res_en = 1'b1;
                        state_in   = S_DONE;
                     end else begin
                        cmd.op   = sple_pkg::DP_RESTART;
                        state_in = S_WALK2;
                     end
                  end
                  default: begin
                     cmd.save       = 1'b1;
                     cmd.res_en     = 1'b1;
                     cmd.res_status = sts.hit ? sple_pkg::ST_OK : sple_pkg::ST_MISSING;
                     state_in       = S_DONE;
                  end
               endcase
            end
         end
         S_WALK2: begin
            if (!sts.done) begin
               cmd.op = sple_pkg::DP_STEP;
            end else if (sts.hit) begin
               cmd.res_en     = 1'b1;
               cmd.res_status = sple_pkg::ST_DUP;
               state_in       = S_DONE;
            end else begin
               cmd.op   = sple_pkg::DP_CHG_UNLINK;
               state_in = S_CHG_A;
            end
         end
         S_INS_A: begin
            cmd.op   = sple_pkg::DP_INS_WR;
            state_in = S_INS_B;
         end
         S_INS_B: begin
            cmd.op     = sple_pkg::DP_INS_LINK;
            cmd.res_en = 1'b1;
            state_in   = S_DONE;
         end
         S_DEL_A: begin
            cmd.op     = sple_pkg::DP_DEL_FREE;
            cmd.res_en = 1'b1;
            state_in   = S_DONE;
         end
         S_CHG_A: begin
            cmd.op   = sple_pkg::DP_CHG_MOVE;
            state_in = S_CHG_B;
         end
         S_CHG_B: begin
            cmd.op     = sple_pkg::DP_CHG_LINK;
            cmd.res_en = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.op   = sple_pkg::DP_LOAD_OUT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/sorted_pool_list_engine.sv
// channel  | ports                                             | dir
// request  | req_valid req_stall req_type req_key req_new_key  | in
//          | req_age req_name_ref                              |
// response | rsp_valid rsp_stall rsp_status rsp_slot rsp_count | out
//
// One request at a time: the list walk visits one record per cycle
// (one link/key memory read per cycle). A change of key walks the list twice.
// Reset is synchronous; the link memory reads its reset chain through
// per-slot valid bits, so no clearing pass is needed.
// A stalled response holds the engine before it takes the next request.
module sorted_pool_list_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_type,
   input  logic signed [31:0]            req_key,
   input  logic signed [31:0]            req_new_key,
   input  logic [7:0]                    req_age,
   input  logic [31:0]                   req_name_ref,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [sple_pkg::SlotW-1:0]    rsp_slot,
   output logic [sple_pkg::LinkW-1:0]    rsp_count
);

   sple_pkg::cmd_type cmd;
   sple_pkg::sts_type sts;

   sple_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sple_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_type     (req_type),
      .req_key      (req_key),
      .req_new_key  (req_new_key),
      .req_age      (req_age),
      .req_name_ref (req_name_ref),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_slot     (rsp_slot),
      .rsp_count    (rsp_count)
   );

endmodule

// File: dv/sorted_pool_list_engine_test.sv
module sorted_pool_list_engine_test;

   localparam int NumRandom = 1800;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [1:0]                      req_type = sple_pkg::REQ_SEARCH;
   logic signed [31:0]              req_key = '0;
   logic signed [31:0]              req_new_key = '0;
   logic [7:0]                      req_age = '0;
   logic [31:0]                     req_name_ref = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [1:0]                      rsp_status;
   logic [sple_pkg::SlotW-1:0]      rsp_slot;
   logic [sple_pkg::LinkW-1:0]      rsp_count;

   int  error_count = 0;
   bit  stim_done = 1'b0;
   bit  rx_hold = 1'b0;
   bit  no_idle = 1'b0;

   sorted_pool_list_engine uut (.*);

   always #5 clock = ~clock;

   task automatic report(input string what);
      $display("mismatch: %s", what);
      error_count++;
   endtask

   typedef struct packed {
      sple_pkg::status_type       status;
      logic [sple_pkg::SlotW-1:0] slot;
      logic [sple_pkg::LinkW-1:0] count;
   } answer_type;

   class list_scoreboard;
      logic signed [31:0] keys [sple_pkg::Capacity];
      int                 links [sple_pkg::Capacity];
      int                 head, free_head, records;
      answer_type         pending [$];

      function new();
         for (int i = 0; i < sple_pkg::Capacity; i++) links[i] = i + 1;
         head = sple_pkg::Capacity;
         free_head = 0;
         records = 0;
      endfunction

      function int lookup(input logic signed [31:0] k, output int prev);
         int cur, p;
         cur = head;
         p = sple_pkg::Capacity;
         while (cur < sple_pkg::Capacity && keys[cur] != k) begin
            p = cur;
            cur = links[cur];
         end
         prev = (cur < sple_pkg::Capacity) ? p : sple_pkg::Capacity;
         return cur;
      endfunction

      function int place(input logic signed [31:0] k);
         int cur, p;
         cur = head;
         p = sple_pkg::Capacity;
         while (cur < sple_pkg::Capacity && keys[cur] < k) begin
            p = cur;
            cur = links[cur];
         end
         return p;
      endfunction

      function void link_in(input int p, input int s);
         if (p < sple_pkg::Capacity) begin
            links[s] = links[p];
            links[p] = s;
         end else begin
            links[s] = head;
            head = s;
         end
      endfunction

      function void unlink(input int p, input int s);
         if (p < sple_pkg::Capacity) links[p] = links[s];
         else head = links[s];
      endfunction

      function bit has_key(input logic signed [31:0] k);
         int p;
         return lookup(k, p) < sple_pkg::Capacity;
      endfunction

      function void note_request(input logic [1:0] kind, input logic signed [31:0] k,
                                 input logic signed [31:0] nk);
         answer_type a;
         int s, p;
         a.status = sple_pkg::ST_OK;
         a.slot = '0;
         case (kind)
            sple_pkg::REQ_INSERT: begin
               if (free_head >= sple_pkg::Capacity) a.status = sple_pkg::ST_FULL;
               else if (has_key(k)) a.status = sple_pkg::ST_DUP;
               else begin
                  p = place(k);
                  s = free_head;
                  free_head = links[s];
                  keys[s] = k;
                  link_in(p, s);
                  records++;
                  a.slot = sple_pkg::SlotW'(s);
               end
            end
            sple_pkg::REQ_DELETE: begin
               s = lookup(k, p);
               if (s >= sple_pkg::Capacity) a.status = sple_pkg::ST_MISSING;
               else begin
                  unlink(p, s);
                  links[s] = free_head;
                  free_head = s;
                  records--;
                  a.slot = sple_pkg::SlotW'(s);
               end
            end
            sple_pkg::REQ_CHANGE: begin
               s = lookup(k, p);
               if (s >= sple_pkg::Capacity) a.status = sple_pkg::ST_MISSING;
               else if (nk == k) a.slot = sple_pkg::SlotW'(s);
               else if (has_key(nk)) a.status = sple_pkg::ST_DUP;
               else begin
                  unlink(p, s);
                  keys[s] = nk;
                  link_in(place(nk), s);
                  a.slot = sple_pkg::SlotW'(s);
               end
            end
            default: begin
               s = lookup(k, p);
               if (s >= sple_pkg::Capacity) a.status = sple_pkg::ST_MISSING;
               else a.slot = sple_pkg::SlotW'(s);
            end
         endcase
         a.count = sple_pkg::LinkW'(records);
         pending.push_back(a);
      endfunction

      task check_answer(input logic [1:0] st, input logic [sple_pkg::SlotW-1:0] sl,
                        input logic [sple_pkg::LinkW-1:0] cnt);
         answer_type a;
         if (pending.size() == 0) begin
            report("response with nothing outstanding");
            return;
         end
         a = pending.pop_front();
         if (st != a.status) report($sformatf("status %0d want %0d", st, a.status));
         if (sl != a.slot) report($sformatf("slot %0d want %0d", sl, a.slot));
         if (cnt != a.count) report($sformatf("count %0d want %0d", cnt, a.count));
      endtask
   endclass

   list_scoreboard board = new();
   logic signed [31:0] used_keys [$];

   task automatic send(input logic [1:0] kind, input logic signed [31:0] k,
                       input logic signed [31:0] nk);
      req_valid <= 1'b1;
      req_type <= kind;
      req_key <= k;
      req_new_key <= nk;
      req_age <= 8'($urandom);
      req_name_ref <= $urandom;
      do @(posedge clock); while (req_stall);
      board.note_request(kind, k, nk);
      if (kind == sple_pkg::REQ_INSERT || kind == sple_pkg::REQ_CHANGE)
         used_keys.push_back(kind == sple_pkg::REQ_INSERT ? k : nk);
      if (!no_idle && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   function automatic logic signed [31:0] pick_key();
      if (used_keys.size() > 0 && $urandom_range(3) != 0)
         return used_keys[$urandom_range(used_keys.size() - 1)];
      if ($urandom_range(1)) return $urandom;
      return $signed($urandom_range(40)) - 20;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_answer(rsp_status, rsp_slot, rsp_count);
      rsp_stall <= rx_hold || (!no_idle && $urandom_range(99) < 35);
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send(sple_pkg::REQ_SEARCH, 32'sh0, 32'sh0);
      send(sple_pkg::REQ_DELETE, 32'sh5, 32'sh0);
      send(sple_pkg::REQ_CHANGE, 32'sh5, 32'sh6);
      send(sple_pkg::REQ_INSERT, 32'sh7fffffff, 32'sh0);
      send(sple_pkg::REQ_INSERT, 32'sh80000000, 32'sh0);
      send(sple_pkg::REQ_INSERT, 32'sh0, 32'shffffffff);
      send(sple_pkg::REQ_INSERT, 32'sh0, 32'sh0);
      send(sple_pkg::REQ_INSERT, -32'sd1, 32'sh0);
      send(sple_pkg::REQ_SEARCH, 32'sh80000000, 32'sh0);
      send(sple_pkg::REQ_SEARCH, 32'sh7fffffff, 32'sh0);
      send(sple_pkg::REQ_CHANGE, 32'sh0, 32'sh0);
      send(sple_pkg::REQ_CHANGE, 32'sh0, -32'sd1);
      send(sple_pkg::REQ_CHANGE, 32'sh0, 32'sh12345678);
      send(sple_pkg::REQ_CHANGE, 32'sh12345678, 32'sh80000000);
      send(sple_pkg::REQ_DELETE, 32'sh7fffffff, 32'sh0);
      send(sple_pkg::REQ_DELETE, 32'sh80000000, 32'sh0);
      send(sple_pkg::REQ_DELETE, -32'sd1, 32'sh0);
      for (int i = 0; i < sple_pkg::Capacity + 3; i++)
         send(sple_pkg::REQ_INSERT, i * 3 - 100, 32'sh0);
      send(sple_pkg::REQ_INSERT, 32'sh7fffffff, 32'sh0);
      fork
         begin
            rx_hold = 1'b1;
            repeat (400) @(posedge clock);
            rx_hold = 1'b0;
         end
         for (int i = 0; i < 12; i++) send(sple_pkg::REQ_SEARCH, i * 3 - 100, -32'sd1);
      join
      for (int i = 0; i < sple_pkg::Capacity; i += 2)
         send(sple_pkg::REQ_DELETE, i * 3 - 100, 32'sh0);
      for (int i = 0; i < NumRandom; i++) begin
         int r;
         no_idle = (i >= 600 && i < 800);
         r = $urandom_range(99);
         if (r < 35) send(sple_pkg::REQ_INSERT, pick_key(), 32'sh0);
         else if (r < 60) send(sple_pkg::REQ_DELETE, pick_key(), 32'sh0);
         else if (r < 80) send(sple_pkg::REQ_CHANGE, pick_key(), pick_key());
         else send(sple_pkg::REQ_SEARCH, pick_key(), 32'sh0);
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      wait (stim_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (error_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin
      #50000000;
      $display("tb: failure");
      $finish;
   end

endmodule

// File: sim.f
design/sple_pkg.sv
design/sple_datapath.sv
design/sple_controller.sv
design/sorted_pool_list_engine.sv
dv/sorted_pool_list_engine_test.sv
